>>> rtl/dfu_pkg.sv
// ----------------------------------------------------------------------------
// dfu_pkg
// Shared widths, request, state, status and reply codes, and the classified
// request item that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package dfu_pkg;

    localparam int OPCODE_W      = 3;
    localparam int LENGTH_W      = 16;
    localparam int KIND_W        = 3;
    localparam int STATUS_W      = 4;
    localparam int STATE_W       = 4;
    localparam int LIMIT_W       = 16;
    localparam int MEM_W         = 25;
    localparam int UPLOAD_ADDR_W = 25;
    localparam int CFG_DATA_W    = 25;
    localparam int CFG_INDEX_W   = 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ALIGN_MASK = 2'h3;

    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSFER_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_BYTES   = 1'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;
    localparam logic [MEM_W-1:0]   MEM_RESET   = 25'd262144;

    localparam logic [OPCODE_W-1:0] REQ_DETACH    = 3'd0;
    localparam logic [OPCODE_W-1:0] REQ_DNLOAD    = 3'd1;
    localparam logic [OPCODE_W-1:0] REQ_UPLOAD    = 3'd2;
    localparam logic [OPCODE_W-1:0] REQ_GETSTATUS = 3'd3;
    localparam logic [OPCODE_W-1:0] REQ_CLRSTATUS = 3'd4;
    localparam logic [OPCODE_W-1:0] REQ_GETSTATE  = 3'd5;
    localparam logic [OPCODE_W-1:0] REQ_ABORT     = 3'd6;

    localparam logic [STATE_W-1:0] ST_APP_IDLE          = 4'd0;
    localparam logic [STATE_W-1:0] ST_APP_DETACH        = 4'd1;
    localparam logic [STATE_W-1:0] ST_IDLE              = 4'd2;
    localparam logic [STATE_W-1:0] ST_DNLOAD_SYNC       = 4'd3;
    localparam logic [STATE_W-1:0] ST_DNBUSY            = 4'd4;
    localparam logic [STATE_W-1:0] ST_DNLOAD_IDLE       = 4'd5;
    localparam logic [STATE_W-1:0] ST_MANIFEST_SYNC     = 4'd6;
    localparam logic [STATE_W-1:0] ST_MANIFEST          = 4'd7;
    localparam logic [STATE_W-1:0] ST_MANIFEST_WAIT_RST = 4'd8;
    localparam logic [STATE_W-1:0] ST_UPLOAD_IDLE       = 4'd9;
    localparam logic [STATE_W-1:0] ST_ERROR             = 4'd10;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 4'd0;
    localparam logic [STATUS_W-1:0] STATUS_ERR_ADDRESS = 4'd8;

    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STALL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ZLP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STATUS = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STATE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DATA   = 3'd5;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [LENGTH_W-1:0] length;
        logic                too_long;
        logic                misaligned;
        logic                zero;
    } t_req;

endpackage

>>> rtl/dfu_request_state_machine.sv
// ----------------------------------------------------------------------------
// dfu_request_state_machine
// DFU 1.0 class-request handler: a front end classifies each request, a
// two-item queue decouples it from the back end that runs the state machine.
// Path: front-end register, then queue, then the back end's reply register.
// Throughput: one request item per cycle while the reply port is not stalled.
// Reset: state dfuIDLE, status ok, upload pointer 0, limits to their defaults.
// ----------------------------------------------------------------------------
module dfu_request_state_machine #(
    parameter int ADDRESS_WIDTH = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [dfu_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic [dfu_pkg::LENGTH_W-1:0]        i_length,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [dfu_pkg::KIND_W-1:0]          o_reply_kind,
    output logic [dfu_pkg::UPLOAD_ADDR_W-1:0]   o_upload_address,
    output logic [dfu_pkg::LENGTH_W-1:0]        o_upload_length,
    output logic [dfu_pkg::STATUS_W-1:0]        o_status_code,
    output logic [dfu_pkg::STATE_W-1:0]         o_state_code,
    input  logic                                i_cfg_we,
    input  logic [dfu_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [dfu_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dfu_pkg::*;

    logic [LIMIT_W-1:0] r_transfer_limit;
    logic [MEM_W-1:0]   r_memory_bytes;
    logic               push;
    logic               full;
    logic               q_valid;
    logic               pop;
    t_req               front_req;
    t_req               q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transfer_limit <= LIMIT_RESET;
            r_memory_bytes   <= MEM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRANSFER_LIMIT: r_transfer_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_MEMORY_BYTES:   r_memory_bytes   <= i_cfg_data[MEM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dfu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_length         (i_length),
        .i_transfer_limit (r_transfer_limit),
        .o_push           (push),
        .o_req            (front_req),
        .i_full           (full)
    );

    dfu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (pop)
    );

    dfu_back #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_req            (q_req),
        .o_pop            (pop),
        .i_memory_bytes   (r_memory_bytes),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_reply_kind     (o_reply_kind),
        .o_upload_address (o_upload_address),
        .o_upload_length  (o_upload_length),
        .o_status_code    (o_status_code),
        .o_state_code     (o_state_code)
    );

endmodule

>>> rtl/dfu_front.sv
// ----------------------------------------------------------------------------
// dfu_front
// Accepts request items, checks the length against the transfer limit and
// the word alignment, and hands the classified item to the queue.
// ----------------------------------------------------------------------------
module dfu_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dfu_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [dfu_pkg::LENGTH_W-1:0]  i_length,
    input  logic [dfu_pkg::LIMIT_W-1:0]   i_transfer_limit,
    output logic                          o_push,
    output dfu_pkg::t_req                 o_req,
    input  logic                          i_full
);
    import dfu_pkg::*;

    logic r_valid;
    logic n_valid;
    t_req r_req;
    logic accept;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_req   = r_req;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.opcode     <= i_opcode;
            r_req.length     <= i_length;
            r_req.too_long   <= i_length > i_transfer_limit;
            r_req.misaligned <= (i_length[1:0] & ALIGN_MASK) != 2'd0;
            r_req.zero       <= i_length == '0;
        end
    end

endmodule

>>> rtl/dfu_queue.sv
// ----------------------------------------------------------------------------
// dfu_queue
// Short first-in first-out queue of classified request items between the
// front end and the back end.
// ----------------------------------------------------------------------------
module dfu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dfu_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_valid,
    output dfu_pkg::t_req o_req,
    input  logic          i_pop
);
    import dfu_pkg::*;

    t_req                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_full  = r_count == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_req   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

>>> rtl/dfu_back.sv
// ----------------------------------------------------------------------------
// dfu_back
// Executes classified requests against the DFU state, error status and
// upload pointer, and holds each reply in an output register.
// ----------------------------------------------------------------------------
module dfu_back #(
    parameter int ADDRESS_WIDTH = 25
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  dfu_pkg::t_req                      i_req,
    output logic                               o_pop,
    input  logic [dfu_pkg::MEM_W-1:0]          i_memory_bytes,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [dfu_pkg::KIND_W-1:0]         o_reply_kind,
    output logic [dfu_pkg::UPLOAD_ADDR_W-1:0]  o_upload_address,
    output logic [dfu_pkg::LENGTH_W-1:0]       o_upload_length,
    output logic [dfu_pkg::STATUS_W-1:0]       o_status_code,
    output logic [dfu_pkg::STATE_W-1:0]        o_state_code
);
    import dfu_pkg::*;

    localparam int CW = ((ADDRESS_WIDTH > MEM_W) ? ADDRESS_WIDTH : MEM_W) + 1;

    logic [STATE_W-1:0]       r_state;
    logic [STATE_W-1:0]       n_state;
    logic [STATUS_W-1:0]      r_status;
    logic [STATUS_W-1:0]      n_status;
    logic [ADDRESS_WIDTH-1:0] r_ptr;
    logic [ADDRESS_WIDTH-1:0] n_ptr;
    logic                     r_valid;
    logic                     n_valid;
    logic [KIND_W-1:0]        r_kind;
    logic [KIND_W-1:0]        n_kind;
    logic [UPLOAD_ADDR_W-1:0] r_waddr;
    logic [UPLOAD_ADDR_W-1:0] n_waddr;
    logic [LENGTH_W-1:0]      r_wlen;
    logic [LENGTH_W-1:0]      n_wlen;

    logic [ADDRESS_WIDTH-1:0] up_base;
    logic [CW-1:0]            ptr_x;
    logic [CW-1:0]            mem_x;
    logic [CW-1:0]            sum_x;
    logic [CW-1:0]            rem_x;
    logic                     up_bad;
    logic                     up_clip;
    logic                     dn_bad;

    assign o_valid          = r_valid;
    assign o_reply_kind     = r_kind;
    assign o_upload_address = r_waddr;
    assign o_upload_length  = r_wlen;
    assign o_status_code    = r_status;
    assign o_state_code     = r_state;
    assign o_pop            = i_q_valid && (!r_valid || !i_stall);

    assign up_base = (r_state == ST_IDLE) ? '0 : r_ptr;
    assign ptr_x   = CW'(up_base);
    assign mem_x   = CW'(i_memory_bytes);
    assign sum_x   = ptr_x + CW'(i_req.length);
    assign rem_x   = mem_x - ptr_x;
    assign up_bad  = i_req.too_long || (ptr_x > mem_x);
    assign up_clip = sum_x > mem_x;
    assign dn_bad  = i_req.too_long || i_req.misaligned;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_ptr    = r_ptr;
        n_kind   = KIND_NONE;
        n_waddr  = '0;
        n_wlen   = '0;
        case (r_state)
            ST_APP_IDLE: begin
                if (i_req.opcode == REQ_DETACH) begin
                    n_state = ST_APP_DETACH;
                    n_kind  = KIND_ZLP;
                end else begin
                    n_kind = KIND_STALL;
                end
            end
            ST_APP_DETACH: begin
                if (i_req.opcode == REQ_GETSTATUS) begin
                    n_kind = KIND_STATUS;
                end else if (i_req.opcode == REQ_GETSTATE) begin
                    n_kind = KIND_STATE;
                end else begin
                    n_state = ST_APP_IDLE;
                    n_kind  = KIND_STALL;
                end
            end
            ST_IDLE, ST_DNLOAD_IDLE, ST_UPLOAD_IDLE: begin
                if (i_req.opcode == REQ_DNLOAD && r_state != ST_UPLOAD_IDLE) begin
                    if (r_state == ST_IDLE && i_req.zero) begin
                        n_state = ST_ERROR;
                        n_kind  = KIND_STALL;
                    end else if (dn_bad) begin
                        n_state  = ST_ERROR;
                        n_status = STATUS_ERR_ADDRESS;
                        n_kind   = KIND_STALL;
                    end else if (i_req.zero) begin
                        n_state = ST_MANIFEST_SYNC;
                    end else begin
                        n_state = ST_DNLOAD_SYNC;
                    end
                end else if (i_req.opcode == REQ_UPLOAD && r_state != ST_DNLOAD_IDLE) begin
                    n_state = ST_UPLOAD_IDLE;
                    n_ptr   = up_base;
                    if (up_bad) begin
                        n_state  = ST_ERROR;
                        n_status = STATUS_ERR_ADDRESS;
                        n_kind   = KIND_STALL;
                    end else begin
                        n_kind  = KIND_DATA;
                        n_waddr = ptr_x[UPLOAD_ADDR_W-1:0];
                        if (up_clip) begin
                            n_wlen  = rem_x[LENGTH_W-1:0];
                            n_ptr   = mem_x[ADDRESS_WIDTH-1:0];
                            n_state = ST_IDLE;
                        end else begin
                            n_wlen = i_req.length;
                            n_ptr  = sum_x[ADDRESS_WIDTH-1:0];
                        end
                    end
                end else if (i_req.opcode == REQ_ABORT) begin
                    n_state = ST_IDLE;
                    n_kind  = KIND_ZLP;
                end else if (i_req.opcode == REQ_GETSTATUS) begin
                    n_kind = KIND_STATUS;
                end else if (i_req.opcode == REQ_GETSTATE) begin
                    n_kind = KIND_STATE;
                end else begin
                    n_state = ST_ERROR;
                    n_kind  = KIND_STALL;
                end
            end
            ST_DNLOAD_SYNC: begin
                if (i_req.opcode == REQ_GETSTATUS) begin
                    n_state = ST_DNLOAD_IDLE;
                    n_kind  = KIND_STATUS;
                end else if (i_req.opcode == REQ_GETSTATE) begin
                    n_kind = KIND_STATE;
                end else begin
                    n_state = ST_ERROR;
                    n_kind  = KIND_STALL;
                end
            end
            ST_MANIFEST_SYNC: begin
                if (i_req.opcode == REQ_GETSTATUS) begin
                    n_kind = KIND_NONE;
                end else if (i_req.opcode == REQ_GETSTATE) begin
                    n_kind = KIND_STATE;
                end else begin
                    n_state = ST_ERROR;
                    n_kind  = KIND_STALL;
                end
            end
            ST_DNBUSY, ST_MANIFEST: begin
                n_state = ST_ERROR;
                n_kind  = KIND_STALL;
            end
            ST_ERROR: begin
                if (i_req.opcode == REQ_GETSTATUS) begin
                    n_kind = KIND_STATUS;
                end else if (i_req.opcode == REQ_GETSTATE) begin
                    n_kind = KIND_STATE;
                end else if (i_req.opcode == REQ_CLRSTATUS) begin
                    n_state  = ST_IDLE;
                    n_status = STATUS_OK;
                    n_kind   = KIND_ZLP;
                end else begin
                    n_kind = KIND_STALL;
                end
            end
            default: begin
                n_kind = KIND_NONE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_state  <= ST_IDLE;
            r_status <= STATUS_OK;
            r_ptr    <= '0;
        end else begin
            r_valid <= n_valid;
            if (o_pop) begin
                r_state  <= n_state;
                r_status <= n_status;
                r_ptr    <= n_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= n_kind;
            r_waddr <= n_waddr;
            r_wlen  <= n_wlen;
        end
    end

endmodule

>>> dv/dfu_request_state_machine_checker.sv
// ----------------------------------------------------------------------------
// dfu_request_state_machine_checker
// Watches the request, reply and register ports of the DFU request handler.
// It runs its own copy of the DFU state machine and queues one reply for each
// accepted request item. Each accepted reply item is compared field by field
// with the oldest queued reply.
// ----------------------------------------------------------------------------
module dfu_request_state_machine_checker #(
    parameter int ADDRESS_WIDTH = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  logic [dfu_pkg::OPCODE_W-1:0]        req_opcode,
    input  logic [dfu_pkg::LENGTH_W-1:0]        req_length,
    input  logic                                rep_valid,
    input  logic                                rep_stall,
    input  logic [dfu_pkg::KIND_W-1:0]          rep_kind,
    input  logic [dfu_pkg::UPLOAD_ADDR_W-1:0]   rep_address,
    input  logic [dfu_pkg::LENGTH_W-1:0]        rep_length,
    input  logic [dfu_pkg::STATUS_W-1:0]        rep_status,
    input  logic [dfu_pkg::STATE_W-1:0]         rep_state,
    input  logic                                cfg_we,
    input  logic [dfu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dfu_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  pending,
    output int                                  failures,
    output int                                  replies
);
    import dfu_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [UPLOAD_ADDR_W-1:0] address;
        logic [LENGTH_W-1:0]      length;
        logic [STATUS_W-1:0]      status;
        logic [STATE_W-1:0]       state;
    } t_reply;

    logic [LIMIT_W-1:0]       transfer_limit = LIMIT_RESET;
    logic [MEM_W-1:0]         memory_bytes = MEM_RESET;
    logic [STATE_W-1:0]       model_state = ST_IDLE;
    logic [STATUS_W-1:0]      model_status = STATUS_OK;
    logic [ADDRESS_WIDTH-1:0] upload_ptr = '0;
    logic [UPLOAD_ADDR_W-1:0] window_addr;
    logic [LENGTH_W-1:0]      window_len;
    t_reply                   replies_due[$];

    initial begin
        pending = 0;
        failures = 0;
        replies = 0;
    end

    function automatic logic [KIND_W-1:0] stall_into_error();
        model_state = ST_ERROR;
        return KIND_STALL;
    endfunction

    function automatic logic [KIND_W-1:0] address_error();
        model_status = STATUS_ERR_ADDRESS;
        return stall_into_error();
    endfunction

    function automatic logic [KIND_W-1:0] take_download(input logic [LENGTH_W-1:0] len);
        if (len > transfer_limit || (len[1:0] & ALIGN_MASK) != 2'd0) begin
            return address_error();
        end
        model_state = (len == '0) ? ST_MANIFEST_SYNC : ST_DNLOAD_SYNC;
        return KIND_NONE;
    endfunction

    function automatic logic [KIND_W-1:0] take_upload(input logic [LENGTH_W-1:0] len);
        longint unsigned base;
        longint unsigned room;
        longint unsigned count;
        base = upload_ptr;
        room = memory_bytes;
        count = len;
        if (len > transfer_limit || base > room) begin
            return address_error();
        end
        if (base + count > room) begin
            count = room - base;
        end
        window_addr = UPLOAD_ADDR_W'(base);
        window_len = LENGTH_W'(count);
        upload_ptr = ADDRESS_WIDTH'(base + count);
        if (count < len) begin
            model_state = ST_IDLE;
        end
        return KIND_DATA;
    endfunction

    function automatic t_reply answer_request(input logic [OPCODE_W-1:0] op,
                                              input logic [LENGTH_W-1:0] len);
        t_reply                 r;
        logic [KIND_W-1:0]      kind;
        window_addr = '0;
        window_len = '0;
        kind = KIND_NONE;
        case (model_state)
            ST_APP_IDLE: begin
                if (op == REQ_DETACH) begin
                    model_state = ST_APP_DETACH;
                    kind = KIND_ZLP;
                end else begin
                    kind = KIND_STALL;
                end
            end
            ST_APP_DETACH: begin
                if (op == REQ_GETSTATUS) begin
                    kind = KIND_STATUS;
                end else if (op == REQ_GETSTATE) begin
                    kind = KIND_STATE;
                end else begin
                    model_state = ST_APP_IDLE;
                    kind = KIND_STALL;
                end
            end
            ST_IDLE: begin
                if (op == REQ_DNLOAD) begin
                    kind = (len == '0) ? stall_into_error() : take_download(len);
                end else if (op == REQ_UPLOAD) begin
                    upload_ptr = '0;
                    model_state = ST_UPLOAD_IDLE;
                    kind = take_upload(len);
                end else if (op == REQ_ABORT) begin
                    kind = KIND_ZLP;
                end else if (op == REQ_GETSTATUS) begin
                    kind = KIND_STATUS;
                end else if (op == REQ_GETSTATE) begin
                    kind = KIND_STATE;
                end else begin
                    kind = stall_into_error();
                end
            end
            ST_DNLOAD_SYNC: begin
                if (op == REQ_GETSTATUS) begin
                    model_state = ST_DNLOAD_IDLE;
                    kind = KIND_STATUS;
                end else if (op == REQ_GETSTATE) begin
                    kind = KIND_STATE;
                end else begin
                    kind = stall_into_error();
                end
            end
            ST_DNLOAD_IDLE: begin
                if (op == REQ_DNLOAD) begin
                    kind = take_download(len);
                end else if (op == REQ_ABORT) begin
                    model_state = ST_IDLE;
                    kind = KIND_ZLP;
                end else if (op == REQ_GETSTATUS) begin
                    kind = KIND_STATUS;
                end else if (op == REQ_GETSTATE) begin
                    kind = KIND_STATE;
                end else begin
                    kind = stall_into_error();
                end
            end
            ST_MANIFEST_SYNC: begin
                if (op == REQ_GETSTATUS) begin
                    kind = KIND_NONE;
                end else if (op == REQ_GETSTATE) begin
                    kind = KIND_STATE;
                end else begin
                    kind = stall_into_error();
                end
            end
            ST_DNBUSY, ST_MANIFEST: begin
                kind = stall_into_error();
            end
            ST_UPLOAD_IDLE: begin
                if (op == REQ_UPLOAD) begin
                    kind = take_upload(len);
                end else if (op == REQ_ABORT) begin
                    model_state = ST_IDLE;
                    kind = KIND_ZLP;
                end else if (op == REQ_GETSTATUS) begin
                    kind = KIND_STATUS;
                end else if (op == REQ_GETSTATE) begin
                    kind = KIND_STATE;
                end else begin
                    kind = stall_into_error();
                end
            end
            ST_ERROR: begin
                if (op == REQ_GETSTATUS) begin
                    kind = KIND_STATUS;
                end else if (op == REQ_GETSTATE) begin
                    kind = KIND_STATE;
                end else if (op == REQ_CLRSTATUS) begin
                    model_state = ST_IDLE;
                    model_status = STATUS_OK;
                    kind = KIND_ZLP;
                end else begin
                    kind = stall_into_error();
                end
            end
            default: begin
                kind = KIND_NONE;
            end
        endcase
        r.kind = kind;
        r.address = window_addr;
        r.length = window_len;
        r.status = model_status;
        r.state = model_state;
        return r;
    endfunction

    always @(posedge clk) begin : watch
        t_reply got;
        t_reply want;
        if (!rst_n) begin
            transfer_limit = LIMIT_RESET;
            memory_bytes = MEM_RESET;
            model_state = ST_IDLE;
            model_status = STATUS_OK;
            upload_ptr = '0;
            replies_due.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TRANSFER_LIMIT) begin
                    transfer_limit = cfg_data[LIMIT_W-1:0];
                end else if (cfg_index == CFG_MEMORY_BYTES) begin
                    memory_bytes = cfg_data[MEM_W-1:0];
                end
            end
            if (req_valid && !req_stall) begin
                replies_due.push_back(answer_request(req_opcode, req_length));
            end
            if (rep_valid && !rep_stall) begin
                got.kind = rep_kind;
                got.address = rep_address;
                got.length = rep_length;
                got.status = rep_status;
                got.state = rep_state;
                if (replies_due.size() == 0) begin
                    failures <= failures + 1;
                    if (failures < 10) begin
                        $display("Reply item with no request outstanding: kind %0d state %0d",
                                 got.kind, got.state);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (got != want) begin
                        failures <= failures + 1;
                        if (failures < 10) begin
                            $display("Reply %0d wrong (expected/actual): kind %0d/%0d",
                                     replies, want.kind, got.kind);
                            $display("  address %0h/%0h length %0d/%0d status %0d/%0d state %0d/%0d",
                                     want.address, got.address, want.length, got.length,
                                     want.status, got.status, want.state, got.state);
                        end
                    end
                end
                replies <= replies + 1;
            end
        end
        pending <= replies_due.size();
    end

endmodule

>>> dv/dfu_request_state_machine_test.sv
// ----------------------------------------------------------------------------
// dfu_request_state_machine_test
// Drives DFU class requests into the request handler: a directed opening over
// the edge cases, then random download, upload, query and noise sequences
// under a range of transfer limits and memory sizes. Both ports idle at
// random. The checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module dfu_request_state_machine_test;
    import dfu_pkg::*;

    localparam logic [OPCODE_W-1:0] REQ_UNKNOWN = 3'd7;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    logic [OPCODE_W-1:0]        req_opcode = REQ_GETSTATE;
    logic [LENGTH_W-1:0]        req_length = '0;
    logic                       rep_valid;
    logic                       rep_stall = 1'b0;
    logic [KIND_W-1:0]          rep_kind;
    logic [UPLOAD_ADDR_W-1:0]   rep_address;
    logic [LENGTH_W-1:0]        rep_length;
    logic [STATUS_W-1:0]        rep_status;
    logic [STATE_W-1:0]         rep_state;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = CFG_TRANSFER_LIMIT;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    int                         pending;
    int                         failures;
    int                         replies;

    bit                         calm = 1'b0;
    int                         sent = 0;
    int                         settings = 1;
    int                         cur_limit = LIMIT_RESET;
    int                         cur_bytes = MEM_RESET;

    dfu_request_state_machine i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_stall          (req_stall),
        .i_opcode         (req_opcode),
        .i_length         (req_length),
        .o_valid          (rep_valid),
        .i_stall          (rep_stall),
        .o_reply_kind     (rep_kind),
        .o_upload_address (rep_address),
        .o_upload_length  (rep_length),
        .o_status_code    (rep_status),
        .o_state_code     (rep_state),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    dfu_request_state_machine_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_opcode  (req_opcode),
        .req_length  (req_length),
        .rep_valid   (rep_valid),
        .rep_stall   (rep_stall),
        .rep_kind    (rep_kind),
        .rep_address (rep_address),
        .rep_length  (rep_length),
        .rep_status  (rep_status),
        .rep_state   (rep_state),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pending     (pending),
        .failures    (failures),
        .replies     (replies)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        rep_stall <= !calm && ($urandom_range(0, 99) < 9);
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic request(input logic [OPCODE_W-1:0] op, input logic [LENGTH_W-1:0] len);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 9) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_opcode <= op;
        req_length <= len;
        do @(posedge clk); while (req_stall);
        sent++;
    endtask

    task automatic drain();
        int waited;
        req_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending != 0 && waited < 5000);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [LIMIT_W-1:0] limit, input logic [MEM_W-1:0] bytes);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TRANSFER_LIMIT;
        cfg_data <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_index <= CFG_MEMORY_BYTES;
        cfg_data <= CFG_DATA_W'(bytes);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_limit = limit;
        cur_bytes = bytes;
        settings++;
    endtask

    function automatic logic [LENGTH_W-1:0] over_limit();
        return LENGTH_W'($urandom_range(cur_limit + 1, 65535));
    endfunction

    task automatic run_sequence();
        int  pick;
        int  count;
        bit  spoiled;
        pick = $urandom_range(0, 99);
        spoiled = 1'b0;
        if (pick < 35) begin
            count = $urandom_range(1, 8);
            for (int b = 0; b < count && !spoiled; b++) begin
                if ($urandom_range(0, 9) == 0) begin
                    if (cur_limit < 65535 && $urandom_range(0, 1) == 1) begin
                        request(REQ_DNLOAD, over_limit());
                    end else begin
                        request(REQ_DNLOAD, LENGTH_W'(($urandom_range(0, 65535) & 32'hFFFC)
                                                      | $urandom_range(1, 3)));
                    end
                    spoiled = 1'b1;
                end else begin
                    request(REQ_DNLOAD, LENGTH_W'(4 * $urandom_range(1, cur_limit / 4)));
                    if ($urandom_range(0, 4) == 0) begin
                        request(REQ_GETSTATE, LENGTH_W'($urandom));
                    end
                    request(REQ_GETSTATUS, LENGTH_W'($urandom));
                end
            end
            if (spoiled) begin
                request(REQ_GETSTATUS, 6);
                request(REQ_CLRSTATUS, 0);
            end else if ($urandom_range(0, 1) == 1) begin
                request(REQ_DNLOAD, 0);
                request(REQ_GETSTATUS, 6);
                request(REQ_GETSTATE, 1);
                request(REQ_CLRSTATUS, 0);
                request(REQ_CLRSTATUS, 0);
            end else begin
                request(REQ_ABORT, 0);
            end
        end else if (pick < 70) begin
            count = $urandom_range(1, 12);
            for (int b = 0; b < count && !spoiled; b++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    request(REQ_UPLOAD, LENGTH_W'(cur_limit));
                end else if (pick < 90 || cur_limit == 65535) begin
                    request(REQ_UPLOAD, LENGTH_W'($urandom_range(0, cur_limit)));
                end else begin
                    request(REQ_UPLOAD, over_limit());
                    spoiled = 1'b1;
                end
            end
            request(REQ_ABORT, 0);
            if (spoiled) begin
                request(REQ_CLRSTATUS, 0);
            end
        end else if (pick < 80) begin
            count = $urandom_range(2, 4);
            repeat (count) begin
                pick = $urandom_range(0, 2);
                request(pick == 0 ? REQ_GETSTATUS : (pick == 1 ? REQ_GETSTATE : REQ_ABORT),
                        LENGTH_W'($urandom));
            end
        end else begin
            count = $urandom_range(1, 5);
            repeat (count) begin
                if ($urandom_range(0, 2) == 0) begin
                    request(OPCODE_W'($urandom_range(0, 7)),
                            LENGTH_W'(4 * $urandom_range(0, cur_limit / 4)));
                end else begin
                    request(OPCODE_W'($urandom_range(0, 7)), LENGTH_W'($urandom));
                end
            end
            request(REQ_DETACH, 0);
            request(REQ_CLRSTATUS, 0);
        end
    endtask

    initial begin
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        request(REQ_GETSTATUS, 16'hFFFF);
        request(REQ_ABORT, 0);
        request(REQ_DNLOAD, 0);
        request(REQ_CLRSTATUS, 0);
        request(REQ_DNLOAD, 6);
        request(REQ_GETSTATUS, 6);
        request(REQ_CLRSTATUS, 0);
        request(REQ_DNLOAD, 260);
        request(REQ_CLRSTATUS, 0);
        request(REQ_DNLOAD, 256);
        request(REQ_GETSTATE, 0);
        request(REQ_GETSTATUS, 0);
        request(REQ_DNLOAD, 4);
        request(REQ_GETSTATUS, 0);
        request(REQ_DNLOAD, 0);
        request(REQ_GETSTATUS, 0);
        request(REQ_ABORT, 0);
        request(REQ_CLRSTATUS, 0);
        request(REQ_UPLOAD, 257);
        request(REQ_CLRSTATUS, 0);
        request(REQ_DETACH, 0);
        request(REQ_UNKNOWN, 16'hFFFF);
        request(REQ_CLRSTATUS, 0);
        drain();
        configure(16'hFFFF, 8);
        request(REQ_UPLOAD, 6);
        drain();
        configure(16'hFFFF, 4);
        request(REQ_UPLOAD, 4);
        request(REQ_CLRSTATUS, 0);
        request(REQ_UPLOAD, 0);
        request(REQ_UPLOAD, 16'hFFFF);

        for (int p = 0; p < 10; p++) begin
            drain();
            case (p)
                0: configure(256, 262144);
                1: configure(4, 1);
                2: configure(16'hFFFF, 25'd16777216);
                3: configure(16, 64);
                4: configure(64, 1000);
                5: configure(16'hFFFF, 1);
                6: configure(4, 25'd16777216);
                7: configure(1024, 5000);
                8: configure(LIMIT_W'($urandom_range(4, 2048)), MEM_W'($urandom_range(1, 8192)));
                default: configure(256, 100);
            endcase
            calm = (p == 2);
            target = sent + 195;
            while (sent < target) begin
                run_sequence();
            end
        end
        calm = 1'b0;
        drain();

        $display("Sent %0d request items over %0d register settings, directed then random.",
                 sent, settings);
        $display("Checked %0d reply items; %0d still outstanding.", replies, pending);
        if (failures == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
